FILE: design/pixel_format_swizzle_converter_top_macros.svh
// Assertion macros used by the pixel format converter top module.
// Each macro expects clk and rst to be visible where it is used.
`ifndef PIXEL_FORMAT_SWIZZLE_CONVERTER_TOP_MACROS_SVH
`define PIXEL_FORMAT_SWIZZLE_CONVERTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFSC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfsc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PFSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfsc assertion failed");

`endif

FILE: design/pfsc_pkg.sv
// Types, codes and helper functions for the pixel format converter.
// No dependencies; every other file of the block but the assertion macros header imports this package.
package pfsc_pkg;

  typedef enum logic [1:0] {
    SRC_R8       = 2'd0,
    SRC_RGB565   = 2'd1,
    SRC_RGB888   = 2'd2,
    SRC_RGBA8888 = 2'd3
  } src_fmt_t;

  typedef enum logic [1:0] {
    DST_RGB565   = 2'd0,
    DST_RGBA4444 = 2'd1,
    DST_RGBA8888 = 2'd2
  } dst_fmt_t;

  typedef enum logic [2:0] {
    SWZ_ZERO    = 3'd0,
    SWZ_ONE     = 3'd1,
    SWZ_RED     = 3'd2,
    SWZ_GREEN   = 3'd3,
    SWZ_BLUE    = 3'd4,
    SWZ_ALPHA   = 3'd5,
    SWZ_INV_RED = 3'd6
  } swz_t;

  typedef enum logic [2:0] {
    CFG_SRC_FORMAT    = 3'd0,
    CFG_DST_FORMAT    = 3'd1,
    CFG_SWIZZLE_RED   = 3'd2,
    CFG_SWIZZLE_GREEN = 3'd3,
    CFG_SWIZZLE_BLUE  = 3'd4,
    CFG_SWIZZLE_ALPHA = 3'd5
  } cfg_idx_t;

  // Full scale of a source component: 1, 31, 63 or 255.
  typedef enum logic [1:0] {
    SCL_ONE = 2'd0,
    SCL_31  = 2'd1,
    SCL_63  = 2'd2,
    SCL_255 = 2'd3
  } scale_t;

  localparam int unsigned CompW = 8;
  localparam int unsigned CfgW  = 3;
  localparam int unsigned PixW  = 32;

  // One output channel after swizzle: component, its full scale and the
  // destination full scale.
  typedef struct packed {
    logic [CompW-1:0] c;
    logic [CompW-1:0] d;
    scale_t           sel;
  } chan_t;

  // Stage advance strobes handed to the rescale lanes.
  typedef struct packed {
    logic adv2;
    logic adv3;
  } adv_t;

  function automatic logic [CompW-1:0] scale_value(input scale_t s);
    logic [CompW-1:0] v;
    case (s)
      SCL_ONE: v = 8'd1;
      SCL_31:  v = 8'd31;
      SCL_63:  v = 8'd63;
      SCL_255: v = 8'd255;
      default: v = 8'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CompW-1:0] dst_max(input dst_fmt_t f, input logic [1:0] lane);
    logic [CompW-1:0] v;
    case (f)
      DST_RGB565: begin
        case (lane)
          2'd1:    v = 8'd63;
          2'd3:    v = 8'd1;
          default: v = 8'd31;
        endcase
      end
      DST_RGBA4444: v = 8'd15;
      DST_RGBA8888: v = 8'd255;
      default:      v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/pfsc_in_if.sv
// Input channel of the pixel format converter: one source pixel per item.
// Uses the widths of pfsc_pkg.
interface pfsc_in_if;
  import pfsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] src_pixel;
  logic            last_pixel;

  modport source(output valid, output src_pixel, output last_pixel, input ready);
  modport sink(input valid, input src_pixel, input last_pixel, output ready);
endinterface

FILE: design/pfsc_out_if.sv
// Output channel of the pixel format converter: one packed pixel per item.
// Uses the widths of pfsc_pkg.
interface pfsc_out_if;
  import pfsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] dst_pixel;
  logic            last_out;

  modport source(output valid, output dst_pixel, output last_out, input ready);
  modport sink(input valid, input dst_pixel, input last_out, output ready);
endinterface

FILE: design/pfsc_unpack.sv
// First pipeline stage: unpacks the source pixel and applies the swizzle.
// Depends on pfsc_pkg.
module pfsc_unpack (
  input  logic                            clk,
  input  logic                            load,
  input  logic [pfsc_pkg::PixW-1:0]       px,
  input  pfsc_pkg::src_fmt_t              src_fmt,
  input  pfsc_pkg::dst_fmt_t              dst_fmt,
  input  pfsc_pkg::swz_t [3:0]            swz,
  output pfsc_pkg::chan_t [3:0]           chan
);
  import pfsc_pkg::*;

  logic [3:0][CompW-1:0] comp;
  scale_t [3:0]          scl;
  logic                  force_alpha;
  chan_t [3:0]           chan_next;

  always_comb begin
    force_alpha = 1'b0;
    case (src_fmt)
      SRC_R8: begin
        comp = {8'd0, 8'd0, 8'd0, px[7:0]};
        scl  = {SCL_ONE, SCL_ONE, SCL_ONE, SCL_255};
      end
      SRC_RGB565: begin
        comp = {8'd1, {3'd0, px[4:0]}, {2'd0, px[10:5]}, {3'd0, px[15:11]}};
        scl  = {SCL_ONE, SCL_31, SCL_63, SCL_31};
      end
      SRC_RGB888: begin
        comp        = {8'd1, px[23:16], px[15:8], px[7:0]};
        scl         = {SCL_ONE, SCL_255, SCL_255, SCL_255};
        force_alpha = 1'b1;
      end
      default: begin
        comp = px;
        scl  = {SCL_255, SCL_255, SCL_255, SCL_255};
      end
    endcase
  end

  // A constant channel is expressed as c over a scale of one, so every lane
  // runs the same rescale arithmetic.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chan_next[i].d = dst_max(dst_fmt, 2'(i));
      case (swz[i])
        SWZ_ZERO: begin
          chan_next[i].c   = 8'd0;
          chan_next[i].sel = SCL_ONE;
        end
        SWZ_ONE: begin
          chan_next[i].c   = 8'd1;
          chan_next[i].sel = SCL_ONE;
        end
        SWZ_RED, SWZ_GREEN, SWZ_BLUE, SWZ_ALPHA: begin
          chan_next[i].c   = comp[2'(swz[i] - SWZ_RED)];
          chan_next[i].sel = scl[2'(swz[i] - SWZ_RED)];
        end
        SWZ_INV_RED: begin
          chan_next[i].c   = scale_value(scl[0]) - comp[0];
          chan_next[i].sel = scl[0];
        end
        default: begin
          chan_next[i].c   = 8'd0;
          chan_next[i].sel = SCL_ONE;
        end
      endcase
      if (force_alpha && i == 3) begin
        chan_next[i].c   = 8'd1;
        chan_next[i].sel = SCL_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chan <= chan_next;
    end
  end

endmodule

FILE: design/pfsc_lane.sv
// Rescale lane: floor(c*d/s) for s of 1, 31, 63 or 255, over two register
// stages and a final fold. Depends on pfsc_pkg.
module pfsc_lane (
  input  logic                   clk,
  input  pfsc_pkg::adv_t         adv,
  input  pfsc_pkg::chan_t        chan,
  output logic [pfsc_pkg::CompW-1:0] q
);
  import pfsc_pkg::*;

  logic [2*CompW-1:0] prod;
  scale_t             sel2;
  logic [CompW-1:0]   q1;
  logic [CompW-1:0]   q1_next;
  logic [8:0]         rem;
  logic [8:0]         rem_next;
  scale_t             sel3;
  logic [3:0]         q2;
  logic [8:0]         r2;
  logic               corr;

  always_ff @(posedge clk) begin
    if (adv.adv2) begin
      prod <= chan.c * chan.d;
      sel2 <= chan.sel;
    end
  end

  // Division by 2^k-1: take p>>k as a first quotient; the remainder is then
  // the low k bits plus that quotient, which is folded once more below.
  always_comb begin
    case (sel2)
      SCL_31: begin
        q1_next  = prod[12:5];
        rem_next = 9'(prod[4:0]) + 9'(q1_next);
      end
      SCL_63: begin
        q1_next  = prod[13:6];
        rem_next = 9'(prod[5:0]) + 9'(q1_next);
      end
      SCL_255: begin
        q1_next  = prod[15:8];
        rem_next = 9'(prod[7:0]) + 9'(q1_next);
      end
      default: begin
        q1_next  = prod[7:0];
        rem_next = 9'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.adv3) begin
      q1   <= q1_next;
      rem  <= rem_next;
      sel3 <= sel2;
    end
  end

  // The second fold leaves a value below twice the divisor, so one compare
  // settles the last quotient bit.
  always_comb begin
    case (sel3)
      SCL_31: begin
        q2   = rem[8:5];
        r2   = 9'(rem[4:0]) + 9'(q2);
        corr = (r2 >= 9'd31);
      end
      SCL_63: begin
        q2   = {1'b0, rem[8:6]};
        r2   = 9'(rem[5:0]) + 9'(q2);
        corr = (r2 >= 9'd63);
      end
      SCL_255: begin
        q2   = {3'd0, rem[8]};
        r2   = 9'(rem[7:0]) + 9'(q2);
        corr = (r2 >= 9'd255);
      end
      default: begin
        q2   = 4'd0;
        r2   = 9'd0;
        corr = 1'b0;
      end
    endcase
    q = q1 + 8'(q2) + 8'(corr);
  end

endmodule

FILE: design/pixel_format_swizzle_converter_top.sv
// Pixel format converter with channel swizzle, four register stages deep.
// Accepts one item per cycle while the output is not stalled.
// Stages: unpack and swizzle, multiply, first fold, second fold and pack.
// Each stage holds its item until the next one frees, so stalls lose nothing.
// Reset (rst, synchronous): pipeline emptied, registers to RGBA8888 identity.
`include "pixel_format_swizzle_converter_top_macros.svh"
module pixel_format_swizzle_converter_top (
  input  logic                       clk,
  input  logic                       rst,
  pfsc_in_if.sink                    pix_in,
  pfsc_out_if.source                 pix_out,
  input  logic                       cfg_we,
  input  logic [pfsc_pkg::CfgW-1:0]  cfg_index,
  input  logic [pfsc_pkg::CfgW-1:0]  cfg_data
);
  import pfsc_pkg::*;

  src_fmt_t          src_format;
  dst_fmt_t          dst_format;
  swz_t [3:0]        swz;

  logic              v1, v2, v3, v4;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic              last1, last2, last3, last4;
  dst_fmt_t          fmt1, fmt2, fmt3, fmt4;
  chan_t [3:0]       chan;
  adv_t              adv;
  logic [3:0][CompW-1:0] q;
  logic [PixW-1:0]   pix_next;
  logic [PixW-1:0]   pix4;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_format <= SRC_RGBA8888;
      dst_format <= DST_RGBA8888;
      swz        <= {SWZ_ALPHA, SWZ_BLUE, SWZ_GREEN, SWZ_RED};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_FORMAT:    src_format <= src_fmt_t'(cfg_data[1:0]);
        CFG_DST_FORMAT:    dst_format <= dst_fmt_t'(cfg_data[1:0]);
        CFG_SWIZZLE_RED:   swz[0]     <= swz_t'(cfg_data);
        CFG_SWIZZLE_GREEN: swz[1]     <= swz_t'(cfg_data);
        CFG_SWIZZLE_BLUE:  swz[2]     <= swz_t'(cfg_data);
        CFG_SWIZZLE_ALPHA: swz[3]     <= swz_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its item moves on this cycle.
  assign rdy4 = !v4 || pix_out.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pix_in.ready = rdy1;
  assign adv.adv2 = rdy2;
  assign adv.adv3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      last1 <= pix_in.last_pixel;
      fmt1  <= dst_format;
    end
    if (rdy2) begin
      last2 <= last1;
      fmt2  <= fmt1;
    end
    if (rdy3) begin
      last3 <= last2;
      fmt3  <= fmt2;
    end
    if (rdy4) begin
      last4 <= last3;
      fmt4  <= fmt3;
      pix4  <= pix_next;
    end
  end

  pfsc_unpack u_unpack (
    .clk     (clk),
    .load    (rdy1),
    .px      (pix_in.src_pixel),
    .src_fmt (src_format),
    .dst_fmt (dst_format),
    .swz     (swz),
    .chan    (chan)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    pfsc_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .chan (chan[i]),
      .q    (q[i])
    );
  end

  always_comb begin
    case (fmt3)
      DST_RGB565:   pix_next = {16'd0, q[0][4:0], q[1][5:0], q[2][4:0]};
      DST_RGBA4444: pix_next = {16'd0, q[0][3:0], q[1][3:0], q[2][3:0], q[3][3:0]};
      DST_RGBA8888: pix_next = {q[0], q[1], q[2], q[3]};
      default:      pix_next = '0;
    endcase
  end

  assign pix_out.valid     = v4;
  assign pix_out.dst_pixel = pix4;
  assign pix_out.last_out  = last4;

  `PFSC_ASSERT_SAME(a_empty_front_ready, !v1, pix_in.ready)
  `PFSC_ASSERT_NEXT(a_accept_fills_front, pix_in.valid && pix_in.ready, v1)
  `PFSC_ASSERT_NEXT(a_dst_format_write,
                    cfg_we && cfg_index == CFG_DST_FORMAT,
                    dst_format == $past(cfg_data[1:0]))
  `PFSC_ASSERT_SAME(a_short_format_high_zero,
                    v4 && (fmt4 == DST_RGB565 || fmt4 == DST_RGBA4444),
                    pix_out.dst_pixel[31:16] == 16'd0)

endmodule
